// File: hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg - planar pose transform shared definitions
// widths, action codes, cordic constants and pipeline side-band types
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int POS_W         = 32;   // Q15.16 position
    localparam int HEAD_W        = 16;   // binary angle
    localparam int ACT_W         = 2;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int ANG_W      = 32;           // angle as a 32-bit turn fraction
    localparam int RES_W      = 30;           // reduced angle, signed
    localparam int SCALE_W    = 32;
    localparam int ZPROD_W    = RES_W + SCALE_W;
    localparam int CW         = 34;           // cordic datapath width
    localparam int TRIG_W     = 32;           // cos / sin, Q2.30
    localparam int OPER_W     = POS_W + 1;    // operand, holds a difference
    localparam int PROD_W     = OPER_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int RND_SHIFT  = 30;
    localparam int ROUND_W    = SUM_W - RND_SHIFT;
    localparam int FINAL_W    = ROUND_W + 2;
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic [ANG_W-1:0] ANGLE_MASK =
        ~((ANG_W'(1) << (ANG_W - ANGLE_BITS)) - ANG_W'(1));
    localparam logic [ANG_W-1:0] OCTANT_BIAS = 32'h2000_0000;

    // radians per turn fraction, Q2.30
    localparam logic signed [SCALE_W-1:0] RAD_SCALE = 32'sd1686629713;
    // cordic start vector, 1/gain in Q2.30
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RND_SHIFT - 1);

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_DEPTH] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    typedef enum logic [ACT_W-1:0] {
        ACT_COMPOSE = 2'd0,
        ACT_EXPRESS = 2'd1,
        ACT_DERIVE  = 2'd2,
        ACT_INVERT  = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [POS_W-1:0]  first_x;
        logic signed [POS_W-1:0]  first_y;
        logic signed [HEAD_W-1:0] first_heading;
        logic signed [POS_W-1:0]  second_x;
        logic signed [POS_W-1:0]  second_y;
        logic signed [HEAD_W-1:0] second_heading;
    } req_t;

    // operands and translation carried alongside the rotation
    typedef struct packed {
        logic signed [OPER_W-1:0] a;
        logic signed [OPER_W-1:0] b;
        logic signed [POS_W-1:0]  tx;
        logic signed [POS_W-1:0]  ty;
        logic                     sub;
        logic                     neg_sin;
        logic [1:0]               quad;
        logic signed [HEAD_W-1:0] heading;
    } side_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
        logic                     sat;
    } result_t;

endpackage

// File: hw/rtl/ppt_in_if.sv
// ----------------------------------------------------------------------------
// ppt_in_if - input channel of the pose transform
// valid/ready channel carrying an action and two poses
// ----------------------------------------------------------------------------
interface ppt_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [ppt_pkg::ACT_W-1:0]                action;
    logic signed [ppt_pkg::POS_W-1:0]         first_x;
    logic signed [ppt_pkg::POS_W-1:0]         first_y;
    logic signed [ppt_pkg::HEAD_W-1:0]        first_heading;
    logic signed [ppt_pkg::POS_W-1:0]         second_x;
    logic signed [ppt_pkg::POS_W-1:0]         second_y;
    logic signed [ppt_pkg::HEAD_W-1:0]        second_heading;

    modport source (
        output valid, action, first_x, first_y, first_heading,
               second_x, second_y, second_heading,
        input  ready
    );
    modport sink (
        input  valid, action, first_x, first_y, first_heading,
               second_x, second_y, second_heading,
        output ready
    );
endinterface

// File: hw/rtl/ppt_out_if.sv
// ----------------------------------------------------------------------------
// ppt_out_if - output channel of the pose transform
// valid/ready channel carrying the resulting pose and saturation flag
// ----------------------------------------------------------------------------
interface ppt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ppt_pkg::POS_W-1:0]     out_x;
    logic signed [ppt_pkg::POS_W-1:0]     out_y;
    logic signed [ppt_pkg::HEAD_W-1:0]    out_heading;
    logic                                 saturated;

    modport source (
        output valid, out_x, out_y, out_heading, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_heading, saturated,
        output ready
    );
endinterface

// File: hw/rtl/planar_pose_transform_core.sv
// ----------------------------------------------------------------------------
// planar_pose_transform_core - planar pose composition, inversion and frames
// pipelined fixed-point SE(2) pose transform with a cordic chain for sin/cos
// ----------------------------------------------------------------------------
//
//   channel   role     word contents
//   -------   ------   ---------------------------------------------------
//   in_ch     sink     action, first pose (x, y, heading), second pose
//   out_ch    source   out_x, out_y, out_heading, saturated
//
// one word accepted per cycle while the pipe advances; stages in order:
// two setup stages, the cordic cell chain, quadrant fix, product and
// rounding stages, output reg
// every stage moves on together; the whole pipe holds only while the output
// register is full and out_ch.ready is low, so in_ch.ready follows that
// reset clears all stage valid bits, payload registers are left as they are
// no clearing pass and no state between words
//
module planar_pose_transform_core (
    input  logic    clk,
    input  logic    rst_n,
    ppt_in_if.sink  in_ch,
    ppt_out_if.source out_ch
);
    import ppt_pkg::*;

    // pipe advance: output register empty or being drained
    logic    advance;
    req_t    req;

    // front to cordic chain
    logic                 front_valid;
    logic signed [CW-1:0] front_z;
    side_t                front_side;

    // cordic chain taps, index 0 is the chain input
    logic                 chain_valid [CORDIC_STAGES+1];
    logic signed [CW-1:0] chain_x     [CORDIC_STAGES+1];
    logic signed [CW-1:0] chain_y     [CORDIC_STAGES+1];
    logic signed [CW-1:0] chain_z     [CORDIC_STAGES+1];
    side_t                chain_side  [CORDIC_STAGES+1];

    // back end result
    logic    res_valid;
    result_t res;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // pack the incoming word
    always_comb
    begin
        req.action         = in_ch.action;
        req.first_x        = in_ch.first_x;
        req.first_y        = in_ch.first_y;
        req.first_heading  = in_ch.first_heading;
        req.second_x       = in_ch.second_x;
        req.second_y       = in_ch.second_y;
        req.second_heading = in_ch.second_heading;
    end

    // operand selection, angle reduction and radian scaling
    ppt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (in_ch.valid),
        .req       (req),
        .z_valid   (front_valid),
        .z         (front_z),
        .side      (front_side)
    );

    // chain input: gain-compensated unit vector on the x axis
    assign chain_valid[0] = front_valid;
    assign chain_x[0]     = CORDIC_X0;
    assign chain_y[0]     = '0;
    assign chain_z[0]     = front_z;
    assign chain_side[0]  = front_side;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        ppt_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_idx (ATAN_IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_x      (chain_x[i]),
            .in_y      (chain_y[i]),
            .in_z      (chain_z[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_x     (chain_x[i+1]),
            .out_y     (chain_y[i+1]),
            .out_z     (chain_z[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // quadrant fix, rotation of the operands, rounding and translation
    // (residual angle of the last cell is not needed)
    ppt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_x      (chain_x[CORDIC_STAGES]),
        .in_y      (chain_y[CORDIC_STAGES]),
        .in_side   (chain_side[CORDIC_STAGES]),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid_next = advance ? res_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result word held until taken
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_x       = out_reg.x;
    assign out_ch.out_y       = out_reg.y;
    assign out_ch.out_heading = out_reg.heading;
    assign out_ch.saturated   = out_reg.sat;

    // a clipped word carries a rail value in at least one position
    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sat |->
            (out_reg.x == POS_MAX) || (out_reg.x == POS_MIN) ||
            (out_reg.y == POS_MAX) || (out_reg.y == POS_MIN))
        else $error("saturated flag without a clipped position");

    // a stall freezes the end of the cordic chain
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_valid[CORDIC_STAGES]))
        else $error("cordic chain moved during a stall");

    // a result word in the back end is not dropped while the output is blocked
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !advance |=> res_valid && out_valid_reg)
        else $error("result word lost under back-pressure");

endmodule

// File: hw/rtl/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front - operand setup and angle reduction
// picks operands per action, reduces the angle to an octant and scales it
// ----------------------------------------------------------------------------
module ppt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           req_valid,
    input  ppt_pkg::req_t                  req,
    output logic                           z_valid,
    output logic signed [ppt_pkg::CW-1:0]  z,
    output ppt_pkg::side_t                 side
);
    import ppt_pkg::*;

    side_t                     side_a;
    logic signed [HEAD_W-1:0]  ang_h;
    logic [ANG_W-1:0]          ang;
    logic [ANG_W-1:0]          ang_biased;
    logic [ANG_W-1:0]          res;
    logic [1:0]                quad;
    logic signed [ZPROD_W-1:0] zprod;

    logic                      a_valid_reg, a_valid_next;
    side_t                     a_side_reg;
    logic signed [RES_W-1:0]   a_r_reg;
    logic                      b_valid_reg, b_valid_next;
    side_t                     b_side_reg;
    logic signed [CW-1:0]      b_z_reg;

    always_comb
    begin
        side_a = '0;
        ang_h  = req.first_heading;
        unique case (action_t'(req.action))
            ACT_COMPOSE:
            begin
                ang_h          = req.first_heading;
                side_a.heading = req.first_heading + req.second_heading;
                side_a.a       = OPER_W'(req.second_x);
                side_a.b       = OPER_W'(req.second_y);
                side_a.tx      = req.first_x;
                side_a.ty      = req.first_y;
            end
            ACT_EXPRESS:
            begin
                ang_h          = req.first_heading;
                side_a.heading = req.second_heading - req.first_heading;
                side_a.a       = OPER_W'(req.second_x) - OPER_W'(req.first_x);
                side_a.b       = OPER_W'(req.second_y) - OPER_W'(req.first_y);
                side_a.neg_sin = 1'b1;
            end
            ACT_DERIVE:
            begin
                ang_h          = req.second_heading - req.first_heading;
                side_a.heading = req.second_heading - req.first_heading;
                side_a.a       = OPER_W'(req.first_x);
                side_a.b       = OPER_W'(req.first_y);
                side_a.tx      = req.second_x;
                side_a.ty      = req.second_y;
                side_a.sub     = 1'b1;
            end
            ACT_INVERT:
            begin
                ang_h          = -req.first_heading;
                side_a.heading = -req.first_heading;
                side_a.a       = OPER_W'(req.first_x);
                side_a.b       = OPER_W'(req.first_y);
                side_a.sub     = 1'b1;
            end
            default:
            begin
                ang_h = req.first_heading;
            end
        endcase

        // quadrant from the nearest axis, remainder within an eighth turn
        ang         = {ang_h, {(ANG_W-HEAD_W){1'b0}}} & ANGLE_MASK;
        ang_biased  = ang + OCTANT_BIAS;
        quad        = ang_biased[ANG_W-1 -: 2];
        res         = ang - {quad, {(ANG_W-2){1'b0}}};
        side_a.quad = quad;
    end

    assign zprod = ZPROD_W'(a_r_reg) * ZPROD_W'(RAD_SCALE);

    assign a_valid_next = advance ? req_valid : a_valid_reg;
    assign b_valid_next = advance ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_side_reg <= side_a;
            a_r_reg    <= $signed(res[RES_W-1:0]);
            b_side_reg <= a_side_reg;
            b_z_reg    <= CW'($signed(zprod[ZPROD_W-1:RND_SHIFT]));
        end
    end

    assign z_valid = b_valid_reg;
    assign z       = b_z_reg;
    assign side    = b_side_reg;

endmodule

// File: hw/rtl/ppt_cordic_cell.sv
// ----------------------------------------------------------------------------
// ppt_cordic_cell - one rotation step of the cordic chain
// rotates toward zero residual angle and passes the word to its neighbor
// ----------------------------------------------------------------------------
module ppt_cordic_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [ppt_pkg::ATAN_IDX_W-1:0]      stage_idx,
    input  logic                                in_valid,
    input  logic signed [ppt_pkg::CW-1:0]       in_x,
    input  logic signed [ppt_pkg::CW-1:0]       in_y,
    input  logic signed [ppt_pkg::CW-1:0]       in_z,
    input  ppt_pkg::side_t                      in_side,
    output logic                                out_valid,
    output logic signed [ppt_pkg::CW-1:0]       out_x,
    output logic signed [ppt_pkg::CW-1:0]       out_y,
    output logic signed [ppt_pkg::CW-1:0]       out_z,
    output ppt_pkg::side_t                      out_side
);
    import ppt_pkg::*;

    logic signed [CW-1:0] sh_x;
    logic signed [CW-1:0] sh_y;
    logic signed [CW-1:0] atan_v;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic                 valid_reg, valid_next;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    side_t                side_reg;

    always_comb
    begin
        sh_x   = in_x >>> stage_idx;
        sh_y   = in_y >>> stage_idx;
        atan_v = ATAN_Q30[stage_idx];
        if (!in_z[CW-1])
        begin
            x_next = in_x - sh_y;
            y_next = in_y + sh_x;
            z_next = in_z - atan_v;
        end
        else
        begin
            x_next = in_x + sh_y;
            y_next = in_y - sh_x;
            z_next = in_z + atan_v;
        end
    end

    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/ppt_back.sv
// ----------------------------------------------------------------------------
// ppt_back - rotation of the operands and translation
// quadrant fix, four products, rounding, translation and saturation
// ----------------------------------------------------------------------------
module ppt_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic signed [ppt_pkg::CW-1:0]  in_x,
    input  logic signed [ppt_pkg::CW-1:0]  in_y,
    input  ppt_pkg::side_t                 in_side,
    output logic                           res_valid,
    output ppt_pkg::result_t               res
);
    import ppt_pkg::*;

    logic signed [CW-1:0]      cos_w, sin_w;
    logic signed [TRIG_W-1:0]  sin_eff;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [FINAL_W-1:0] fin_x, fin_y;
    logic                      clip_x, clip_y;

    // trig stage
    logic                      t_valid_reg, t_valid_next;
    logic signed [TRIG_W-1:0]  t_cos_reg, t_sin_reg;
    side_t                     t_side_reg;
    // product stage
    logic                      m_valid_reg, m_valid_next;
    logic signed [PROD_W-1:0]  m_ac_reg, m_bs_reg, m_as_reg, m_bc_reg;
    side_t                     m_side_reg;
    // rounding stage
    logic                      r_valid_reg, r_valid_next;
    logic signed [ROUND_W-1:0] r_x_reg, r_y_reg;
    side_t                     r_side_reg;

    always_comb
    begin
        unique case (in_side.quad)
            2'd0:
            begin
                cos_w = in_x;
                sin_w = in_y;
            end
            2'd1:
            begin
                cos_w = -in_y;
                sin_w = in_x;
            end
            2'd2:
            begin
                cos_w = -in_x;
                sin_w = -in_y;
            end
            default:
            begin
                cos_w = in_y;
                sin_w = -in_x;
            end
        endcase
        sin_eff = in_side.neg_sin ? -TRIG_W'(sin_w) : TRIG_W'(sin_w);
    end

    always_comb
    begin
        sum_x = SUM_W'(m_ac_reg) - SUM_W'(m_bs_reg) + ROUND_HALF;
        sum_y = SUM_W'(m_as_reg) + SUM_W'(m_bc_reg) + ROUND_HALF;
    end

    always_comb
    begin
        if (r_side_reg.sub)
        begin
            fin_x = FINAL_W'(r_side_reg.tx) - FINAL_W'(r_x_reg);
            fin_y = FINAL_W'(r_side_reg.ty) - FINAL_W'(r_y_reg);
        end
        else
        begin
            fin_x = FINAL_W'(r_side_reg.tx) + FINAL_W'(r_x_reg);
            fin_y = FINAL_W'(r_side_reg.ty) + FINAL_W'(r_y_reg);
        end
        // in range when all bits above the result sign agree with it
        clip_x = (fin_x[FINAL_W-1:POS_W-1] != {(FINAL_W-POS_W+1){fin_x[FINAL_W-1]}});
        clip_y = (fin_y[FINAL_W-1:POS_W-1] != {(FINAL_W-POS_W+1){fin_y[FINAL_W-1]}});
        res.x       = clip_x ? (fin_x[FINAL_W-1] ? POS_MIN : POS_MAX) : POS_W'(fin_x);
        res.y       = clip_y ? (fin_y[FINAL_W-1] ? POS_MIN : POS_MAX) : POS_W'(fin_y);
        res.heading = r_side_reg.heading;
        res.sat     = clip_x | clip_y;
    end

    assign t_valid_next = advance ? in_valid : t_valid_reg;
    assign m_valid_next = advance ? t_valid_reg : m_valid_reg;
    assign r_valid_next = advance ? m_valid_reg : r_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= t_valid_next;
            m_valid_reg <= m_valid_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_cos_reg  <= TRIG_W'(cos_w);
            t_sin_reg  <= sin_eff;
            t_side_reg <= in_side;
            m_ac_reg   <= PROD_W'(t_side_reg.a) * PROD_W'(t_cos_reg);
            m_bs_reg   <= PROD_W'(t_side_reg.b) * PROD_W'(t_sin_reg);
            m_as_reg   <= PROD_W'(t_side_reg.a) * PROD_W'(t_sin_reg);
            m_bc_reg   <= PROD_W'(t_side_reg.b) * PROD_W'(t_cos_reg);
            m_side_reg <= t_side_reg;
            r_x_reg    <= ROUND_W'(sum_x >>> RND_SHIFT);
            r_y_reg    <= ROUND_W'(sum_y >>> RND_SHIFT);
            r_side_reg <= m_side_reg;
        end
    end

    assign res_valid = r_valid_reg;

endmodule
